// ===== hdl/assert_macros.svh =====
// Assertion macros used by the heap engine top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, switched off while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Condition that must never be seen while out of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

// ===== hdl/mhs_pkg.sv =====
// Shared types, widths and codes of the min-heap sort engine.
package mhs_pkg;

   // Field widths
   localparam int DATA_W = 32;
   localparam int CMD_W  = 3;
   localparam int IDX_W  = 6;
   localparam int CNT_W  = 7;
   localparam int ST_W   = 2;

   // Default number of heap entries
   localparam int CAPACITY_DEF = 32;

   // Value returned when the heap holds nothing
   localparam logic signed [DATA_W-1:0] EMPTY_VALUE = 32'sh7FFF_FFFF;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_BUILD    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_EXTRACT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DECREASE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DRAIN    = 3'd4;

   // Status codes
   localparam logic [ST_W-1:0] ST_OK       = 2'd0;
   localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [ST_W-1:0] ST_RANGE    = 2'd3;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_BLD_NEXT,
      S_LOAD,
      S_EX_RD0,
      S_EX_RDL,
      S_EX_LOAD,
      S_SD_CHK,
      S_SD_RDR,
      S_SD_CMPR,
      S_SD_CMPC,
      S_SU_CHK,
      S_SU_CMP,
      S_RESP
   } state_type;

   // What the current command does once a sift has finished
   typedef enum logic [1:0] {
      MODE_SINGLE,
      MODE_BUILD,
      MODE_DRAIN
   } mode_type;

endpackage

// ===== hdl/mhs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mhs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/min_heap_sort_engine.sv =====
// Top level of the min-heap sort engine: sequencer, shared comparator and heap store.
// Append, decrease-key errors and unknown commands go from idle to the response state, which
// passes their item on once the output register is free. Extract time follows the sift-down
// loop, which per level runs check, read and compare states on the single store read port
// and one comparator. Build runs that loop once per inner node; drain repeats extract once
// per entry. One command is worked on at a time; synchronous reset empties the heap at once.
`include "assert_macros.svh"

module min_heap_sort_engine #(
   parameter int CAPACITY = mhs_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mhs_pkg::CMD_W-1:0]         req_command,
   input  logic signed [mhs_pkg::DATA_W-1:0] req_value,
   input  logic [mhs_pkg::IDX_W-1:0]         req_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [mhs_pkg::DATA_W-1:0] rsp_result_value,
   output logic [mhs_pkg::ST_W-1:0]          rsp_status,
   output logic                              rsp_last,
   output logic [mhs_pkg::CNT_W-1:0]         rsp_entry_count
);

   import mhs_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = CNT_W + 1;

   // Control state
   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Working registers of the sift loops
   logic [AW-1:0]            pos_ff, pos_in;
   logic [AW-1:0]            cand_idx_ff, cand_idx_in;
   logic [AW-1:0]            bld_ff, bld_in;
   logic signed [DATA_W-1:0] cur_ff, cur_in;
   logic signed [DATA_W-1:0] cand_ff, cand_in;
   logic signed [DATA_W-1:0] res_val_ff, res_val_in;
   logic [ST_W-1:0]          res_st_ff, res_st_in;

   // Output register
   logic signed [DATA_W-1:0] rsp_val_ff, rsp_val_in;
   logic [ST_W-1:0]          rsp_st_ff, rsp_st_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic [CNT_W-1:0]         rsp_cnt_ff, rsp_cnt_in;

   // Store ports
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic signed [DATA_W-1:0] wr_data;
   logic [AW-1:0]            rd_addr;
   logic signed [DATA_W-1:0] rd_data;

   // Shared comparator
   logic signed [DATA_W-1:0] cmp_a;
   logic signed [DATA_W-1:0] cmp_b;
   logic                     cmp_lt;

   // Tree arithmetic around the current position
   logic [CW-1:0]    l_w;
   logic [CW-1:0]    r_w;
   logic [CW-1:0]    n_w;
   logic             l_ok;
   logic             r_ok;
   logic [AW-1:0]    l_addr;
   logic [AW-1:0]    r_addr;
   logic [AW-1:0]    parent;
   logic [CNT_W-1:0] occ_dec;
   state_type        sift_done;

   mhs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cmp_lt = cmp_a < cmp_b;

   // Children, parent and the last occupied slot of the current position
   assign l_w       = CW'({pos_ff, 1'b1});
   assign r_w       = l_w + CW'(1);
   assign n_w       = CW'(occ_ff);
   assign l_ok      = l_w < n_w;
   assign r_ok      = r_w < n_w;
   assign l_addr    = l_w[AW-1:0];
   assign r_addr    = r_w[AW-1:0];
   assign parent    = (pos_ff - AW'(1)) >> 1;
   assign occ_dec   = occ_ff - CNT_W'(1);
   assign sift_done = (mode_ff == MODE_BUILD) ? S_BLD_NEXT : S_RESP;

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_val_ff;
   assign rsp_status       = rsp_st_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_entry_count  = rsp_cnt_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_SINGLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      cand_idx_ff <= cand_idx_in;
      bld_ff      <= bld_in;
      cur_ff      <= cur_in;
      cand_ff     <= cand_in;
      res_val_ff  <= res_val_in;
      res_st_ff   <= res_st_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_last_ff <= rsp_last_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   // Sequencer: next state, store accesses and comparator operands
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      occ_in       = occ_ff;
      pos_in       = pos_ff;
      cand_idx_in  = cand_idx_ff;
      bld_in       = bld_ff;
      cur_in       = cur_ff;
      cand_in      = cand_ff;
      res_val_in   = res_val_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_val_in   = rsp_val_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = cur_ff;
      rd_addr      = '0;
      cmp_a        = cur_ff;
      cmp_b        = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in    = MODE_SINGLE;
               res_val_in = '0;
               res_st_in  = ST_OK;
               state_in   = S_RESP;
               case (req_command)
                  CMD_APPEND: begin
                     if (occ_ff >= CNT_W'(CAPACITY)) begin
                        res_st_in = ST_OVERFLOW;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = occ_ff[AW-1:0];
                        wr_data = req_value;
                        occ_in  = occ_ff + CNT_W'(1);
                     end
                  end
                  CMD_BUILD: begin
                     mode_in  = MODE_BUILD;
                     bld_in   = occ_ff[AW:1];
                     state_in = S_BLD_NEXT;
                  end
                  CMD_EXTRACT: begin
                     if (occ_ff == '0) begin
                        res_val_in = EMPTY_VALUE;
                        res_st_in  = ST_EMPTY;
                     end else begin
                        state_in = S_EX_RD0;
                     end
                  end
                  CMD_DECREASE: begin
                     if (CNT_W'(req_index) >= occ_ff) begin
                        res_st_in = ST_RANGE;
                     end else begin
                        pos_in   = req_index[AW-1:0];
                        cur_in   = req_value;
                        state_in = S_SU_CHK;
                     end
                  end
                  CMD_DRAIN: begin
                     if (occ_ff == '0) begin
                        res_val_in = EMPTY_VALUE;
                        res_st_in  = ST_EMPTY;
                     end else begin
                        mode_in  = MODE_DRAIN;
                        state_in = S_EX_RD0;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         // Bottom-up build: fetch the next inner node and sift it down
         S_BLD_NEXT: begin
            if (bld_ff == '0) begin
               state_in = S_RESP;
            end else begin
               bld_in   = bld_ff - AW'(1);
               rd_addr  = bld_ff - AW'(1);
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cur_in   = rd_data;
            pos_in   = bld_ff;
            state_in = S_SD_CHK;
         end

         // Extraction: take the root, move the last entry up and sift it down
         S_EX_RD0: begin
            rd_addr  = '0;
            state_in = S_EX_RDL;
         end
         S_EX_RDL: begin
            res_val_in = rd_data;
            res_st_in  = ST_OK;
            rd_addr    = occ_dec[AW-1:0];
            occ_in     = occ_dec;
            pos_in     = '0;
            state_in   = S_EX_LOAD;
         end
         S_EX_LOAD: begin
            cur_in   = rd_data;
            state_in = S_SD_CHK;
         end

         // Sift-down: read the children, pick the smaller, compare with the moving value
         S_SD_CHK: begin
            if (!l_ok) begin
               wr_en    = 1'b1;
               state_in = sift_done;
            end else begin
               rd_addr  = l_addr;
               state_in = S_SD_RDR;
            end
         end
         S_SD_RDR: begin
            cand_in     = rd_data;
            cand_idx_in = l_addr;
            if (r_ok) begin
               rd_addr  = r_addr;
               state_in = S_SD_CMPR;
            end else begin
               state_in = S_SD_CMPC;
            end
         end
         S_SD_CMPR: begin
            cmp_a = rd_data;
            cmp_b = cand_ff;
            if (cmp_lt) begin
               cand_in     = rd_data;
               cand_idx_in = r_addr;
            end
            state_in = S_SD_CMPC;
         end
         S_SD_CMPC: begin
            cmp_a = cand_ff;
            cmp_b = cur_ff;
            wr_en = 1'b1;
            if (cmp_lt) begin
               wr_data  = cand_ff;
               pos_in   = cand_idx_ff;
               state_in = S_SD_CHK;
            end else begin
               state_in = sift_done;
            end
         end

         // Sift-up for decrease-key: pull larger parents down one level at a time
         S_SU_CHK: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_RESP;
            end else begin
               rd_addr  = parent;
               state_in = S_SU_CMP;
            end
         end
         S_SU_CMP: begin
            cmp_a = cur_ff;
            cmp_b = rd_data;
            wr_en = 1'b1;
            if (cmp_lt) begin
               wr_data  = rd_data;
               pos_in   = parent;
               state_in = S_SU_CHK;
            end else begin
               state_in = S_RESP;
            end
         end

         // Hand the item to the output register once it is free
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = res_val_ff;
               rsp_st_in    = res_st_ff;
               rsp_cnt_in   = occ_ff;
               rsp_last_in  = (mode_ff != MODE_DRAIN) || (occ_ff == '0);
               if ((mode_ff == MODE_DRAIN) && (occ_ff != '0)) begin
                  state_in = S_EX_RD0;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The heap never holds more entries than the store has slots.
   `ASSERT_NEVER(a_occ_cap, occ_ff > CNT_W'(CAPACITY), "occupancy above capacity")

   // Every store write lands at or below the current fill level.
   `ASSERT_CLK(a_wr_range,
      wr_en |-> (CNT_W'(wr_addr) <= occ_ff),
      "store write beyond fill level")

   // Occupancy moves by at most one entry per cycle.
   `ASSERT_CLK(a_occ_step,
      (!$past(reset) && (occ_ff != $past(occ_ff))) |->
         ((occ_ff == $past(occ_ff) + CNT_W'(1)) || (occ_ff == $past(occ_ff) - CNT_W'(1))),
      "occupancy jumped")

   // An empty report carries the largest value and a zero count.
   `ASSERT_CLK(a_empty_rsp,
      (rsp_valid && (rsp_status == ST_EMPTY)) |->
         ((rsp_result_value == EMPTY_VALUE) && (rsp_entry_count == '0)),
      "bad empty report")

endmodule
